// ----- design/mlsw_pkg.sv -----
// Shared types and constants for the multi-leg book sweep VWAP block.
// Used by every module of the block but mlsw_div; depends on nothing.
package mlsw_pkg;

	localparam int MAX_LEGS_DEF   = 8;
	localparam int MAX_LEVELS_DEF = 16;

	localparam int SLOT_W     = 4;
	localparam int CNT_W      = 7;
	localparam int NL_W       = 5;
	localparam int CAP_W      = 32 + CNT_W;
	localparam int FIFO_DEPTH = 4;

	localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INV_LEG  = 3'd1;
	localparam logic [2:0] ST_NO_BOOK  = 3'd2;
	localparam logic [2:0] ST_NO_SIDE  = 3'd3;
	localparam logic [2:0] ST_BAD_QTY  = 3'd4;
	localparam logic [2:0] ST_THIN     = 3'd5;

	localparam logic [1:0] CHK_NO_BOOK = 2'd1;
	localparam logic [1:0] CHK_INV     = 2'd2;
	localparam logic [1:0] CHK_NO_ASK  = 2'd3;

	typedef struct packed {
		logic                lvl_wr;
		logic [SLOT_W-1:0]   slot;
		logic [CNT_W-1:0]    lvl;
		logic signed [31:0]  price;
		logic [31:0]         size;
		logic                close;
		logic [2:0]          leg;
		logic signed [31:0]  ratio;
		logic [CAP_W-1:0]    cap;
		logic [31:0]         best;
		logic [CNT_W-1:0]    cnt;
		logic                last;
		logic [NL_W-1:0]     n_legs;
		logic [2:0]          status;
	} mlsw_entry_t;

endpackage

// ----- design/multi_leg_book_sweep_vwap_top.sv -----
// Top level of the multi-leg book sweep VWAP block.
// Instantiates mlsw_front, mlsw_fifo and mlsw_back; uses mlsw_pkg.
//
// Levels are taken one item per cycle while the four-entry queue between the
// front and back end has room. On the last_leg item the back end works the
// bundle: a capacity division for each leg, then for each leg the planned
// lots, the level sweep and a VWAP division, then the bundle average and the
// result rows, paced by the shared one-bit-per-cycle divider and the single
// level memory read port. A failing bundle emits only its summary row. While
// the back end is busy the front end keeps accepting items until the queue
// fills.
module multi_leg_book_sweep_vwap_top
	import mlsw_pkg::*;
#(
	parameter int MAX_LEGS   = MAX_LEGS_DEF,
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         leg_number,
	input  logic [1:0]         leg_check,
	input  logic               level_present,
	input  logic signed [31:0] level_price_tick,
	input  logic [31:0]        level_size,
	input  logic signed [31:0] leg_ratio_lots,
	input  logic               last_level,
	input  logic               last_leg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_summary,
	output logic [2:0]         row_leg,
	output logic [2:0]         status,
	output logic [62:0]        leg_capacity,
	output logic [62:0]        leg_planned_lots,
	output logic signed [63:0] leg_spend,
	output logic signed [63:0] leg_vwap,
	output logic [30:0]        leg_worst_price,
	output logic [62:0]        bundle_count,
	output logic signed [63:0] total_cost,
	output logic signed [63:0] average_cost,
	output logic [31:0]        max_slippage
);

	mlsw_entry_t wr_entry, rd_entry;
	logic        push, pop, fifo_full, fifo_empty;

	mlsw_front #(
		.MAX_LEGS   (MAX_LEGS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.leg_number       (leg_number),
		.leg_check        (leg_check),
		.level_present    (level_present),
		.level_price_tick (level_price_tick),
		.level_size       (level_size),
		.leg_ratio_lots   (leg_ratio_lots),
		.last_level       (last_level),
		.last_leg         (last_leg),
		.fifo_full        (fifo_full),
		.push             (push),
		.entry            (wr_entry)
	);

	mlsw_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (wr_entry),
		.rd     (pop),
		.rdata  (rd_entry),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	mlsw_back #(
		.MAX_LEGS   (MAX_LEGS),
		.MAX_LEVELS (MAX_LEVELS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.fifo_empty       (fifo_empty),
		.entry            (rd_entry),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.is_summary       (is_summary),
		.row_leg          (row_leg),
		.status           (status),
		.leg_capacity     (leg_capacity),
		.leg_planned_lots (leg_planned_lots),
		.leg_spend        (leg_spend),
		.leg_vwap         (leg_vwap),
		.leg_worst_price  (leg_worst_price),
		.bundle_count     (bundle_count),
		.total_cost       (total_cost),
		.average_cost     (average_cost),
		.max_slippage     (max_slippage)
	);

endmodule

// ----- design/mlsw_front.sv -----
// Front end: accepts level items, tracks per-leg counts, capacity, best price
// and leg errors, and pushes one classified entry per item. Uses mlsw_pkg.
module mlsw_front
	import mlsw_pkg::*;
#(
	parameter int MAX_LEGS   = MAX_LEGS_DEF,
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         leg_number,
	input  logic [1:0]         leg_check,
	input  logic               level_present,
	input  logic signed [31:0] level_price_tick,
	input  logic [31:0]        level_size,
	input  logic signed [31:0] leg_ratio_lots,
	input  logic               last_level,
	input  logic               last_leg,
	input  logic               fifo_full,
	output logic               push,
	output mlsw_entry_t        entry
);

	logic [NL_W-1:0]  legs_q, legs_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [CAP_W-1:0] cap_q, cap_n;
	logic [31:0]      best_q, best_n;
	logic [2:0]       err_q, err_n, e;
	logic             tml_q, tml_n;
	logic             full, lvl_ok, good, close;

	assign in_ready = !fifo_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		full   = legs_q >= NL_W'(MAX_LEGS);
		lvl_ok = !full && level_present && (cnt_q < CNT_W'(MAX_LEVELS));
		good   = (level_price_tick > 32'sd0) && (level_size != 32'd0);
		cnt_n  = cnt_q + CNT_W'(lvl_ok);
		cap_n  = (lvl_ok && good) ? cap_q + CAP_W'(level_size) : cap_q;
		best_n = (lvl_ok && good && best_q == 32'd0) ? level_price_tick : best_q;
		close  = !full && (last_level || last_leg);
		if (leg_check == CHK_NO_BOOK) begin
			e = ST_NO_BOOK;
		end else if (leg_ratio_lots <= 32'sd0) begin
			e = ST_BAD_QTY;
		end else if (leg_check == CHK_INV) begin
			e = ST_INV_LEG;
		end else if (leg_check == CHK_NO_ASK || cnt_n == '0) begin
			e = ST_NO_SIDE;
		end else begin
			e = ST_OK;
		end
		err_n  = (close && err_q == ST_OK) ? e : err_q;
		legs_n = legs_q + NL_W'(close);
		tml_n  = tml_q | full;

		entry.lvl_wr = lvl_ok;
		entry.slot   = legs_q[SLOT_W-1:0];
		entry.lvl    = cnt_q;
		entry.price  = level_price_tick;
		entry.size   = level_size;
		entry.close  = close;
		entry.leg    = leg_number;
		entry.ratio  = leg_ratio_lots;
		entry.cap    = cap_n;
		entry.best   = best_n;
		entry.cnt    = cnt_n;
		entry.last   = last_leg;
		entry.n_legs = legs_n;
		entry.status = tml_n ? ST_INV_LEG : err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			legs_q <= '0;
			cnt_q  <= '0;
			cap_q  <= '0;
			best_q <= '0;
			err_q  <= ST_OK;
			tml_q  <= 1'b0;
		end else if (push) begin
			if (last_leg) begin
				legs_q <= '0;
				cnt_q  <= '0;
				cap_q  <= '0;
				best_q <= '0;
				err_q  <= ST_OK;
				tml_q  <= 1'b0;
			end else begin
				legs_q <= legs_n;
				err_q  <= err_n;
				tml_q  <= tml_n;
				if (close) begin
					cnt_q  <= '0;
					cap_q  <= '0;
					best_q <= '0;
				end else begin
					cnt_q  <= cnt_n;
					cap_q  <= cap_n;
					best_q <= best_n;
				end
			end
		end
	end

endmodule

// ----- design/mlsw_fifo.sv -----
// Short entry queue between front and back end.
// Uses mlsw_pkg for the entry type and depth.
module mlsw_fifo
	import mlsw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  mlsw_entry_t wdata,
	input  logic        rd,
	output mlsw_entry_t rdata,
	output logic        full,
	output logic        empty
);

	localparam int PW = $clog2(FIFO_DEPTH);

	mlsw_entry_t      mem_q [FIFO_DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;

	assign full  = cnt_q == (PW+1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

endmodule

// ----- design/mlsw_div.sv -----
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// Standalone; depends on nothing.
module mlsw_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, quo_q, den_q;
	logic [64:0] trial;
	logic        ge;

	assign done = done_q;
	assign quo  = quo_q;

	always_comb begin
		trial = {rem_q, quo_q[63]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ----- design/mlsw_back.sv -----
// Back end: level memory, per-leg stores, bundle count, sweep, VWAP and
// result rows. Uses mlsw_pkg and the mlsw_div divider.
module mlsw_back
	import mlsw_pkg::*;
#(
	parameter int MAX_LEGS   = MAX_LEGS_DEF,
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fifo_empty,
	input  mlsw_entry_t        entry,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_summary,
	output logic [2:0]         row_leg,
	output logic [2:0]         status,
	output logic [62:0]        leg_capacity,
	output logic [62:0]        leg_planned_lots,
	output logic signed [63:0] leg_spend,
	output logic signed [63:0] leg_vwap,
	output logic [30:0]        leg_worst_price,
	output logic [62:0]        bundle_count,
	output logic signed [63:0] total_cost,
	output logic signed [63:0] average_cost,
	output logic [31:0]        max_slippage
);

	localparam int DEPTH = MAX_LEGS * MAX_LEVELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;

	typedef enum logic [14:0] {
		B_IDLE = 15'b000000000000001,
		B_CAP  = 15'b000000000000010,
		B_CAPW = 15'b000000000000100,
		B_M0   = 15'b000000000001000,
		B_M1   = 15'b000000000010000,
		B_M2   = 15'b000000000100000,
		B_RD   = 15'b000000001000000,
		B_DAT  = 15'b000000010000000,
		B_ACC  = 15'b000000100000000,
		B_END  = 15'b000001000000000,
		B_VW   = 15'b000010000000000,
		B_AVG  = 15'b000100000000000,
		B_AVGW = 15'b001000000000000,
		B_EMIT = 15'b010000000000000,
		B_WAIT = 15'b100000000000000
	} bstate_t;

	bstate_t state_q;

	logic signed [31:0] price_mem [DEPTH];
	logic [31:0]        size_mem  [DEPTH];

	logic signed [31:0] ratio_r   [MAX_LEGS];
	logic [CAP_W-1:0]   cap_r     [MAX_LEGS];
	logic [31:0]        best_r    [MAX_LEGS];
	logic [CNT_W-1:0]   cnt_r     [MAX_LEGS];
	logic [2:0]         leg_r     [MAX_LEGS];
	logic [63:0]        planned_r [MAX_LEGS];
	logic [63:0]        cost_r    [MAX_LEGS];
	logic [63:0]        vwap_r    [MAX_LEGS];
	logic [31:0]        worst_r   [MAX_LEGS];

	logic [2:0]         status_q;
	logic [NL_W-1:0]    n_q, i_q;
	logic [CNT_W-1:0]   l_q;
	logic [63:0]        bundle_q, want_q, rem_q, c_q, total_q, avg_q, mul_q;
	logic [31:0]        w_q, slip_q, take_q, pr_q;
	logic signed [31:0] rd_price_q;
	logic [31:0]        rd_size_q;

	logic [SW-1:0]      ix;
	logic [AW-1:0]      rd_addr, wr_addr;
	logic [31:0]        mul_a, mul_b, take, slip_n;
	logic [63:0]        want_n, ratio64;
	logic               div_start, div_done;
	logic [63:0]        div_num, div_den, div_quo;
	logic               sum_row;

	mlsw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		ix      = i_q[SW-1:0];
		pop     = (state_q == B_IDLE) && !fifo_empty;
		wr_addr = AW'(entry.slot[SW-1:0] * MAX_LEVELS + entry.lvl);
		rd_addr = AW'(ix * MAX_LEVELS + l_q);
		ratio64 = {32'd0, ratio_r[ix]};
		want_n  = want_q + {mul_q[31:0], 32'd0};
		take    = (rem_q < {32'd0, rd_size_q}) ? rem_q[31:0] : rd_size_q;
		slip_n  = w_q - best_r[ix];
		sum_row = (status_q != ST_OK) || (i_q == n_q);
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			B_M0: begin
				mul_a = ratio_r[ix];
				mul_b = bundle_q[31:0];
			end
			B_M1: begin
				mul_a = ratio_r[ix];
				mul_b = bundle_q[63:32];
			end
			B_DAT: begin
				mul_a = take;
				mul_b = rd_price_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			B_CAP: begin
				div_start = (i_q != n_q) && !({25'd0, cap_r[ix]} < ratio64);
				div_num   = {25'd0, cap_r[ix]};
				div_den   = ratio64;
			end
			B_END: begin
				div_start = (rem_q == '0) && !(c_q > I64_MAX - total_q);
				div_num   = c_q;
				div_den   = want_q;
			end
			B_AVG: begin
				div_start = 1'b1;
				div_num   = total_q + bundle_q - 64'd1;
				div_den   = bundle_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		if (pop && entry.lvl_wr) begin
			price_mem[wr_addr] <= entry.price;
			size_mem[wr_addr]  <= entry.size;
		end
		if (state_q == B_RD) begin
			rd_price_q <= price_mem[rd_addr];
			rd_size_q  <= size_mem[rd_addr];
		end
		if (pop && entry.close) begin
			ratio_r[entry.slot[SW-1:0]] <= entry.ratio;
			cap_r[entry.slot[SW-1:0]]   <= entry.cap;
			best_r[entry.slot[SW-1:0]]  <= entry.best;
			cnt_r[entry.slot[SW-1:0]]   <= entry.cnt;
			leg_r[entry.slot[SW-1:0]]   <= entry.leg;
		end
		if (state_q == B_END) begin
			planned_r[ix] <= want_q;
			cost_r[ix]    <= c_q;
			worst_r[ix]   <= w_q;
		end
		if (state_q == B_VW && div_done) begin
			vwap_r[ix] <= div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			status_q  <= ST_OK;
			n_q       <= '0;
			i_q       <= '0;
			l_q       <= '0;
			bundle_q  <= '0;
			want_q    <= '0;
			rem_q     <= '0;
			c_q       <= '0;
			w_q       <= '0;
			total_q   <= '0;
			slip_q    <= '0;
			avg_q     <= '0;
			take_q    <= '0;
			pr_q      <= '0;
			out_valid <= 1'b0;
			is_summary       <= 1'b0;
			row_leg          <= '0;
			status           <= ST_OK;
			leg_capacity     <= '0;
			leg_planned_lots <= '0;
			leg_spend        <= '0;
			leg_vwap         <= '0;
			leg_worst_price  <= '0;
			bundle_count     <= '0;
			total_cost       <= '0;
			average_cost     <= '0;
			max_slippage     <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop && entry.last) begin
						status_q <= entry.status;
						n_q      <= entry.n_legs;
						i_q      <= '0;
						bundle_q <= '1;
						total_q  <= '0;
						slip_q   <= '0;
						state_q  <= (entry.status != ST_OK) ? B_EMIT : B_CAP;
					end
				end
				B_CAP: begin
					if (i_q == n_q) begin
						i_q <= '0;
						if (bundle_q == '0) begin
							status_q <= ST_THIN;
							state_q  <= B_EMIT;
						end else begin
							state_q <= B_M0;
						end
					end else if ({25'd0, cap_r[ix]} < ratio64) begin
						status_q <= ST_THIN;
						state_q  <= B_EMIT;
					end else begin
						state_q <= B_CAPW;
					end
				end
				B_CAPW: begin
					if (div_done) begin
						if (div_quo < bundle_q) bundle_q <= div_quo;
						i_q     <= i_q + 1'b1;
						state_q <= B_CAP;
					end
				end
				B_M0: state_q <= B_M1;
				B_M1: begin
					want_q  <= mul_q;
					state_q <= B_M2;
				end
				B_M2: begin
					want_q  <= want_n;
					rem_q   <= want_n;
					c_q     <= '0;
					w_q     <= '0;
					l_q     <= '0;
					state_q <= B_RD;
				end
				B_RD: begin
					state_q <= (l_q < cnt_r[ix] && rem_q != '0) ? B_DAT : B_END;
				end
				B_DAT: begin
					if (rd_price_q <= 32'sd0 || rd_size_q == '0) begin
						l_q     <= l_q + 1'b1;
						state_q <= B_RD;
					end else begin
						take_q  <= take;
						pr_q    <= rd_price_q;
						state_q <= B_ACC;
					end
				end
				B_ACC: begin
					if (mul_q > I64_MAX - c_q) begin
						status_q <= ST_INV_LEG;
						state_q  <= B_EMIT;
					end else begin
						c_q     <= c_q + mul_q;
						if (pr_q > w_q) w_q <= pr_q;
						rem_q   <= rem_q - {32'd0, take_q};
						l_q     <= l_q + 1'b1;
						state_q <= B_RD;
					end
				end
				B_END: begin
					if (rem_q != '0) begin
						status_q <= ST_THIN;
						state_q  <= B_EMIT;
					end else begin
						if (slip_n > slip_q) slip_q <= slip_n;
						if (c_q > I64_MAX - total_q) begin
							status_q <= ST_INV_LEG;
							state_q  <= B_EMIT;
						end else begin
							total_q <= total_q + c_q;
							state_q <= B_VW;
						end
					end
				end
				B_VW: begin
					if (div_done) begin
						i_q     <= i_q + 1'b1;
						state_q <= (i_q + 1'b1 == n_q) ? B_AVG : B_M0;
					end
				end
				B_AVG: state_q <= B_AVGW;
				B_AVGW: begin
					if (div_done) begin
						avg_q   <= div_quo;
						i_q     <= '0;
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					out_valid        <= 1'b1;
					is_summary       <= sum_row;
					row_leg          <= sum_row ? 3'd0 : leg_r[ix];
					status           <= sum_row ? status_q : ST_OK;
					leg_capacity     <= sum_row ? '0 : 63'(cap_r[ix]);
					leg_planned_lots <= sum_row ? '0 : planned_r[ix][62:0];
					leg_spend        <= sum_row ? '0 : cost_r[ix];
					leg_vwap         <= sum_row ? '0 : vwap_r[ix];
					leg_worst_price  <= sum_row ? '0 : worst_r[ix][30:0];
					if (sum_row && status_q == ST_OK) begin
						bundle_count <= bundle_q[62:0];
						total_cost   <= total_q;
						average_cost <= avg_q;
						max_slippage <= slip_q;
					end else begin
						bundle_count <= '0;
						total_cost   <= '0;
						average_cost <= '0;
						max_slippage <= '0;
					end
					state_q <= B_WAIT;
				end
				B_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (is_summary) begin
							state_q <= B_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= B_EMIT;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
